// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check macros used by the deque unit; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that post holds in the same cycle as pre
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication violated");

// Check that post holds in the cycle after pre
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ----- design/dbq_pkg.sv -----
// ----------------------------------------------------------------------------
// Deque package
// Transaction types, operation and status codes, FSM state and cell control types.
// ----------------------------------------------------------------------------
package dbq_pkg;

   localparam int WORD_W   = 32;
   localparam int DATA_W   = 40;
   localparam int OPCODE_W = 3;
   localparam int COUNT_W  = 5;

   // Operation codes carried in the request opcode field
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_READ_BACK  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_MEAN       = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_DIVIDE,
      FSM_RESPOND
   } fsm_state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic signed [WORD_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] data_out;
      logic                     is_empty;
      logic [COUNT_W-1:0]       entry_count;
   } rsp_item_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [WORD_W-1:0] word;
   } cell_ctrl_type;

endpackage

// ----- design/dbq_cell.sv -----
// ----------------------------------------------------------------------------
// Deque cell
// One entry of the queue; shifts towards either neighbour or loads a word.
// ----------------------------------------------------------------------------
module dbq_cell (
   input  logic                              clock,
   input  dbq_pkg::cell_ctrl_type            ctrl_in,
   input  logic signed [dbq_pkg::WORD_W-1:0] lower_word,
   input  logic signed [dbq_pkg::WORD_W-1:0] upper_word,
   output logic signed [dbq_pkg::WORD_W-1:0] word_out
);
   import dbq_pkg::*;

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;

   // Select the next entry: hold, take a neighbour's word, or load
   always_comb begin
      unique case (ctrl_in.op)
         CELL_HOLD:       word_in = word_ff;
         CELL_SHIFT_UP:   word_in = lower_word;
         CELL_SHIFT_DOWN: word_in = upper_word;
         CELL_LOAD:       word_in = ctrl_in.word;
         default:         word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

// ----- design/dbq_divider.sv -----
// ----------------------------------------------------------------------------
// Deque divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbq_divider #(
   parameter int DIVIDEND_W = 45,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   import dbq_pkg::*;

   localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

   logic                  active_ff, active_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [DIVISOR_W:0]    rem_shifted;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;

   // Shift in the next dividend bit and try a subtraction
   always_comb begin
      rem_shifted = {rem_ff, shift_ff[DIVIDEND_W-1]};
      rem_diff    = rem_shifted - {1'b0, divisor_ff};
      fits        = (rem_shifted >= {1'b0, divisor_ff});
   end

   // Advance the iteration; quotient bits fill the shift register from below
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      shift_in  = shift_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         rem_in    = '0;
         shift_in  = dividend;
      end else if (active_ff) begin
         rem_in   = fits ? rem_diff[DIVISOR_W-1:0] : rem_shifted[DIVISOR_W-1:0];
         shift_in = {shift_ff[DIVIDEND_W-2:0], fits};
         step_in  = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      if (start) begin
         divisor_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

// ----- design/bounded_deque_with_average_unit.sv -----
// ----------------------------------------------------------------------------
// Bounded deque with average
// Deque of signed words in a row of shifting cells, with a running mean.
// ----------------------------------------------------------------------------
// Each accepted transaction produces exactly one result, shown for a single
// cycle under rsp_strobe; the receiver cannot hold it off, so it must take
// it in that cycle. Push, pop, read back, unused opcodes and any operation
// on an empty queue give their result in the cycle after acceptance, and
// busy drops in the cycle after that. A mean on a non-empty queue runs the
// restoring divider at one quotient bit per cycle over all QW dividend
// bits, with QW = clog2(QUEUE_DEPTH+1) + 32 + FRACTION_BITS, which is 45
// bits at the default settings. The back entry always sits in the first cell,
// so read and pop never search the row.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_deque_with_average_unit #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  dbq_pkg::req_item_type req_item,
   output logic                  busy,
   output logic                  rsp_strobe,
   output dbq_pkg::rsp_item_type rsp_item
);
   import dbq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = WORD_W + CNT_W;
   localparam int QW    = SUM_W + FRACTION_BITS;
   localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(QUEUE_DEPTH);

   fsm_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic                     neg_ff;
   rsp_item_type             rsp_ff;
   rsp_item_type             rsp_in;

   logic                     accept;
   logic                     full;
   logic                     empty;
   logic                     push_front_ok;
   logic                     push_back_ok;
   logic                     pop_ok;
   logic                     mean_go;
   status_type               status_in;
   logic signed [DATA_W-1:0] data_in;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   logic signed [WORD_W-1:0] cell_word [QUEUE_DEPTH];
   cell_ctrl_type            cell_ctrl [QUEUE_DEPTH];

   logic [SUM_W-1:0]         sum_abs;
   logic [QW-1:0]            div_dividend;
   logic                     div_start;
   logic                     div_done;
   logic [QW-1:0]            div_quotient;
   logic [QW-1:0]            mean_mag;
   logic signed [QW+DATA_W-1:0] mean_wide;

   assign accept = start && !busy;
   assign full   = (count_ff >= DEPTH_COUNT);
   assign empty  = (count_ff == '0);

   // Decode the accepted transaction and work out the new count and sum
   always_comb begin
      push_front_ok = 1'b0;
      push_back_ok  = 1'b0;
      pop_ok        = 1'b0;
      mean_go       = 1'b0;
      status_in     = STATUS_OK;
      data_in       = '0;
      count_in      = count_ff;
      sum_in        = sum_ff;
      if (accept) begin
         unique case (req_item.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  push_front_ok = (req_item.opcode == OP_PUSH_FRONT);
                  push_back_ok  = (req_item.opcode == OP_PUSH_BACK);
                  count_in      = count_ff + CNT_W'(1);
                  sum_in        = sum_ff + SUM_W'(req_item.value);
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  pop_ok   = 1'b1;
                  count_in = count_ff - CNT_W'(1);
                  sum_in   = sum_ff - SUM_W'(cell_word[0]);
               end
            end
            OP_READ_BACK: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  data_in = DATA_W'(cell_word[0]);
               end
            end
            OP_MEAN: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  mean_go = 1'b1;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   // Assemble the response fields; truncate the count to the field width
   always_comb begin
      count_wide           = (CNT_W + COUNT_W)'(count_in);
      rsp_in.status        = status_in;
      rsp_in.data_out      = data_in;
      rsp_in.is_empty      = (count_in == '0);
      rsp_in.entry_count   = count_wide[COUNT_W-1:0];
   end

   // Drive each cell: the back entry lives in cell 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      always_comb begin
         cell_ctrl[i].word = req_item.value;
         priority if (push_back_ok) begin
            cell_ctrl[i].op = CELL_SHIFT_UP;
         end else if (pop_ok) begin
            cell_ctrl[i].op = CELL_SHIFT_DOWN;
         end else if (push_front_ok && (count_ff == CNT_W'(i))) begin
            cell_ctrl[i].op = CELL_LOAD;
         end else begin
            cell_ctrl[i].op = CELL_HOLD;
         end
      end

      if (i == 0) begin : g_first
         if (QUEUE_DEPTH > 1) begin : g_link
            dbq_cell u_cell (
               .clock      (clock),
               .ctrl_in    (cell_ctrl[i]),
               .lower_word (req_item.value),
               .upper_word (cell_word[i+1]),
               .word_out   (cell_word[i])
            );
         end
      end else if (i == QUEUE_DEPTH - 1) begin : g_last
         dbq_cell u_cell (
            .clock      (clock),
            .ctrl_in    (cell_ctrl[i]),
            .lower_word (cell_word[i-1]),
            .upper_word (cell_word[i]),
            .word_out   (cell_word[i])
         );
      end else begin : g_mid
         dbq_cell u_cell (
            .clock      (clock),
            .ctrl_in    (cell_ctrl[i]),
            .lower_word (cell_word[i-1]),
            .upper_word (cell_word[i+1]),
            .word_out   (cell_word[i])
         );
      end
   end

   // Scale the sum magnitude and hand it to the divider
   assign div_start    = mean_go;
   assign sum_abs      = sum_ff[SUM_W-1] ? unsigned'(-sum_ff) : unsigned'(sum_ff);
   assign div_dividend = QW'(sum_abs) << FRACTION_BITS;

   dbq_divider #(
      .DIVIDEND_W (QW),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Restore the sign; truncation toward zero falls out of the magnitude split
   assign mean_mag  = neg_ff ? (~div_quotient + QW'(1)) : div_quotient;
   assign mean_wide = (QW + DATA_W)'(signed'(mean_mag));

   // Next state
   always_comb begin
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = mean_go ? FSM_DIVIDE : FSM_RESPOND;
            end else begin
               state_in = FSM_IDLE;
            end
         end
         FSM_DIVIDE:  state_in = div_done ? FSM_RESPOND : FSM_DIVIDE;
         FSM_RESPOND: state_in = FSM_IDLE;
         default:     state_in = FSM_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      unique case (state_ff)
         FSM_IDLE: begin
            busy       = 1'b0;
            rsp_strobe = 1'b0;
         end
         FSM_DIVIDE: begin
            busy       = 1'b1;
            rsp_strobe = 1'b0;
         end
         FSM_RESPOND: begin
            busy       = 1'b1;
            rsp_strobe = 1'b1;
         end
         default: begin
            busy       = 1'b1;
            rsp_strobe = 1'b0;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // Capture the response; the mean overwrites its data when the divider ends
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
         neg_ff <= sum_ff[SUM_W-1];
      end else if (div_done) begin
         rsp_ff.data_out <= mean_wide[DATA_W-1:0];
      end
   end

   assign rsp_item = rsp_ff;

   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_COUNT)
   `ASSERT_NEXT(a_short_op_responds, clock, reset, accept && !mean_go, rsp_strobe)
   `ASSERT_NEXT(a_divide_responds, clock, reset, div_done, rsp_strobe)
   `ASSERT_IMPLY(a_full_flag_when_full, clock, reset, rsp_strobe && rsp_item.status == STATUS_FULL, count_ff == DEPTH_COUNT)

endmodule
